@@ hw/rtl/nec_ir_sampled_frame_decoder_core_defines.svh @@
// assertion macros for the nec ir sampled frame decoder
`ifndef NEC_IR_SAMPLED_FRAME_DECODER_CORE_DEFINES_SVH
`define NEC_IR_SAMPLED_FRAME_DECODER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define NIRD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nird: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define NIRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nird: next-cycle check failed");

`endif

@@ hw/rtl/nird_pkg.sv @@
// constants shared by the nec ir sampled frame decoder
package nird_pkg;

    localparam int unsigned STORE_BITS = 256;
    localparam int unsigned AW         = $clog2(STORE_BITS);
    localparam int unsigned POS_W      = AW + 1;
    localparam int unsigned CW         = $clog2(STORE_BITS + 1);

    localparam int unsigned DATA_BITS  = 32;

    localparam logic [7:0]  TIMEOUT_RESET    = 8'd155;
    localparam logic [7:0]  TICK_LIMIT       = 8'hff;
    localparam int unsigned LEADER_MIN_TICKS = 18;
    localparam int unsigned STOP_MIN_SAMPLES = 20;
    localparam logic [15:0] STOP_PATTERN     = 16'h8000;
    localparam int unsigned LEAD_HIGH_MIN    = 14;
    localparam int unsigned LEAD_SCAN_LAST   = 16;
    localparam int unsigned LEAD_LOW_A       = 16;
    localparam int unsigned LEAD_LOW_B       = 17;
    localparam int unsigned SYNC_LAST        = 4;
    localparam int unsigned SYNC_SPAN        = 8;
    localparam int unsigned SKIP_LAST        = 7;
    localparam int unsigned TRIPLET_LAST     = 2;

    localparam logic [2:0]  PAT_ONE  = 3'b100;
    localparam logic [2:0]  PAT_ZERO = 3'b101;
    localparam logic [4:0]  SYNC_REPEAT = 5'b00001;
    localparam logic [4:0]  SYNC_FRAME  = 5'b00000;

    localparam logic [1:0]  KIND_FRAME  = 2'd0;
    localparam logic [1:0]  KIND_REPEAT = 2'd1;
    localparam logic [1:0]  KIND_ERROR  = 2'd2;

    localparam logic        REG_STRICT  = 1'b0;
    localparam logic        REG_TIMEOUT = 1'b1;

endpackage

@@ hw/rtl/nec_ir_sampled_frame_decoder_core.sv @@
// nec ir frame decoder: tick capture into a bit store and a sample-serial decode
//
//  channel   direction  handshake                    payload
//  tick      in         start high, busy low         i_ir_present
//  result    out        o_strobe, one cycle          o_frame_kind, o_address_word,
//                                                    o_command_byte, o_command_inverse
//  config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// an ordinary tick is taken while busy stays low
// the first tick after the stop pattern is complete starts a decode (after an overflow it
// ends with an error result instead); the decode walks the sample memory one bit at a time
// through its single registered read port
// synchronous active-low reset; no clearing pass, reads at or above the fill count give zero
// the result strobe cannot be held off and is high for exactly one cycle
module nec_ir_sampled_frame_decoder_core
    import nird_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_ir_present,
    output logic        o_strobe,
    output logic [1:0]  o_frame_kind,
    output logic [15:0] o_address_word,
    output logic [7:0]  o_command_byte,
    output logic [7:0]  o_command_inverse,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

`include "nec_ir_sampled_frame_decoder_core_defines.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAP   = 3'd1;
    localparam logic [2:0] S_LEAD  = 3'd2;
    localparam logic [2:0] S_LDEND = 3'd3;
    localparam logic [2:0] S_SYNC  = 3'd4;
    localparam logic [2:0] S_SKIP  = 3'd5;
    localparam logic [2:0] S_BITS  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic             r_strict;
    logic [7:0]       r_timeout;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [7:0]       r_tick, n_tick;
    logic             r_ovf, n_ovf;
    logic             r_lead_bad, n_lead_bad;
    logic [15:0]      r_last16, n_last16;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_addr, n_addr;
    logic             r_wait, n_wait;
    logic [2:0]       r_j, n_j;
    logic [4:0]       r_bit, n_bit;
    logic [2:0]       r_pat, n_pat;
    logic [4:0]       r_low, n_low;
    logic [31:0]      r_data, n_data;

    logic             r_mem [STORE_BITS];
    logic             r_rd_bit;
    logic             r_rd_ok;
    logic             r_rd_oob;

    logic             fin;
    logic [1:0]       fin_kind;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;

    logic             capturing;
    logic             tick_acc;
    logic             stop_hit;
    logic             timeout_hit;
    logic             lead_fail;
    logic             smp;

    assign capturing   = (r_state == S_CAP);
    assign busy        = (r_state != S_IDLE) && (r_state != S_CAP);
    assign tick_acc    = start && !busy && (capturing || i_ir_present);
    assign stop_hit    = (r_cnt >= CW'(STOP_MIN_SAMPLES)) && (r_last16 == STOP_PATTERN);
    assign timeout_hit = (r_tick > r_timeout) || (r_tick == TICK_LIMIT);
    assign lead_fail   = (r_tick >= 8'(LEADER_MIN_TICKS)) && r_lead_bad;
    // samples at or above the fill count read as a cleared store
    assign smp         = r_rd_bit && r_rd_ok;

    always_comb begin
        logic [CW-1:0]    cnt_base;
        logic [7:0]       tick_base;
        logic             ir;
        logic [2:0]       np;
        logic             bitv;
        logic [31:0]      nd;
        logic [POS_W-1:0] npos;

        cnt_base   = capturing ? r_cnt : '0;
        tick_base  = capturing ? r_tick : '0;
        ir         = i_ir_present;
        np         = {r_pat[1:0], smp};
        bitv       = (np == PAT_ONE);
        nd         = {bitv, r_data[31:1]};
        npos       = bitv ? r_pos + POS_W'(4) : r_pos + POS_W'(2);

        n_state    = r_state;
        n_cnt      = r_cnt;
        n_tick     = r_tick;
        n_ovf      = r_ovf;
        n_lead_bad = r_lead_bad;
        n_last16   = r_last16;
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_wait     = 1'b0;
        n_j        = r_j;
        n_bit      = r_bit;
        n_pat      = r_pat;
        n_low      = r_low;
        n_data     = r_data;
        fin        = 1'b0;
        fin_kind   = KIND_ERROR;
        mem_we     = 1'b0;
        mem_wa     = cnt_base[AW-1:0];

        unique case (r_state)
            S_IDLE, S_CAP: begin
                if (tick_acc) begin
                    if (capturing && stop_hit) begin
                        if (r_ovf) begin
                            fin = 1'b1;
                        end else begin
                            n_state = S_LEAD;
                            n_pos   = '0;
                            n_addr  = '0;
                            n_wait  = 1'b1;
                        end
                    end else if (capturing && (timeout_hit || lead_fail)) begin
                        n_state = S_IDLE;
                    end else begin
                        // a fresh capture starts from empty counters
                        n_state    = S_CAP;
                        n_tick     = tick_base + 8'd1;
                        n_ovf      = capturing ? r_ovf : 1'b0;
                        n_cnt      = cnt_base;
                        n_last16   = capturing ? r_last16 : '0;
                        n_lead_bad = capturing ? r_lead_bad : 1'b0;
                        if (cnt_base >= CW'(STORE_BITS)) begin
                            n_ovf = 1'b1;
                        end else begin
                            mem_we   = 1'b1;
                            n_cnt    = cnt_base + CW'(1);
                            n_last16 = {n_last16[14:0], ir};
                            if ((cnt_base < CW'(LEAD_HIGH_MIN)) && !ir) begin
                                n_lead_bad = 1'b1;
                            end
                            if (((cnt_base == CW'(LEAD_LOW_A)) ||
                                 (cnt_base == CW'(LEAD_LOW_B))) && ir) begin
                                n_lead_bad = 1'b1;
                            end
                        end
                    end
                end
            end
            S_LEAD: begin
                if (!r_wait) begin
                    if (smp && (r_pos != POS_W'(LEAD_SCAN_LAST))) begin
                        n_pos  = r_pos + POS_W'(1);
                        n_addr = r_pos + POS_W'(1);
                        n_wait = 1'b1;
                    end else begin
                        if (smp) begin
                            n_pos = r_pos + POS_W'(1);
                        end
                        n_state = S_LDEND;
                    end
                end
            end
            S_LDEND: begin
                if (r_strict) begin
                    if ((r_pos < POS_W'(LEAD_HIGH_MIN)) || (r_pos > POS_W'(LEAD_SCAN_LAST))) begin
                        fin = 1'b1;
                    end else begin
                        n_state = S_SYNC;
                        n_addr  = r_pos;
                        n_wait  = 1'b1;
                        n_j     = '0;
                        n_low   = '0;
                    end
                end else begin
                    n_state = S_SKIP;
                    n_addr  = r_pos;
                    n_wait  = 1'b1;
                    n_j     = '0;
                end
            end
            S_SYNC: begin
                if (!r_wait) begin
                    n_low = {r_low[3:0], smp};
                    if (r_rd_oob) begin
                        fin = 1'b1;
                    end else if (r_j != 3'(SYNC_LAST)) begin
                        n_j    = r_j + 3'd1;
                        n_addr = r_addr + POS_W'(1);
                        n_wait = 1'b1;
                    end else if (n_low == SYNC_REPEAT) begin
                        fin      = 1'b1;
                        fin_kind = KIND_REPEAT;
                    end else if (n_low == SYNC_FRAME) begin
                        n_state = S_BITS;
                        n_pos   = r_pos + POS_W'(SYNC_SPAN);
                        n_addr  = r_pos + POS_W'(SYNC_SPAN);
                        n_wait  = 1'b1;
                        n_j     = '0;
                        n_bit   = '0;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_SKIP: begin
                if (!r_wait) begin
                    if (r_rd_oob) begin
                        fin = 1'b1;
                    end else if (smp) begin
                        n_state = S_BITS;
                        n_addr  = r_pos;
                        n_wait  = 1'b1;
                        n_j     = '0;
                        n_bit   = '0;
                    end else begin
                        n_pos  = r_pos + POS_W'(1);
                        n_addr = r_pos + POS_W'(1);
                        n_wait = 1'b1;
                        if (r_j == 3'(SKIP_LAST)) begin
                            n_state = S_BITS;
                            n_j     = '0;
                            n_bit   = '0;
                        end else begin
                            n_j = r_j + 3'd1;
                        end
                    end
                end
            end
            S_BITS: begin
                if (!r_wait) begin
                    n_pat = np;
                    if (r_rd_oob) begin
                        fin = 1'b1;
                    end else if (r_j != 3'(TRIPLET_LAST)) begin
                        n_j    = r_j + 3'd1;
                        n_addr = r_addr + POS_W'(1);
                        n_wait = 1'b1;
                    end else if ((np == PAT_ONE) || (np == PAT_ZERO)) begin
                        n_data = nd;
                        n_pos  = npos;
                        if (r_bit == 5'(DATA_BITS - 1)) begin
                            fin      = 1'b1;
                            // command byte and its inverse must complement
                            fin_kind = ((nd[23:16] ^ nd[31:24]) == 8'hff) ? KIND_FRAME
                                                                         : KIND_ERROR;
                        end else begin
                            n_bit  = r_bit + 5'd1;
                            n_j    = '0;
                            n_addr = npos;
                            n_wait = 1'b1;
                        end
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strict   <= 1'b1;
            r_timeout  <= TIMEOUT_RESET;
            r_cnt      <= '0;
            r_tick     <= '0;
            r_ovf      <= 1'b0;
            r_lead_bad <= 1'b0;
            r_last16   <= '0;
            o_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_tick     <= n_tick;
            r_ovf      <= n_ovf;
            r_lead_bad <= n_lead_bad;
            r_last16   <= n_last16;
            o_strobe   <= fin;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_STRICT:  r_strict  <= i_cfg_data[0];
                    REG_TIMEOUT: r_timeout <= i_cfg_data;
                    default:     r_strict  <= r_strict;
                endcase
            end
        end
    end

    // decode walk and result payload
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_addr <= n_addr;
        r_wait <= n_wait;
        r_j    <= n_j;
        r_bit  <= n_bit;
        r_pat  <= n_pat;
        r_low  <= n_low;
        r_data <= n_data;
        if (fin) begin
            o_frame_kind <= fin_kind;
            if (fin_kind == KIND_FRAME) begin
                o_address_word    <= n_data[15:0];
                o_command_byte    <= n_data[23:16];
                o_command_inverse <= n_data[31:24];
            end else begin
                o_address_word    <= '0;
                o_command_byte    <= '0;
                o_command_inverse <= '0;
            end
        end
    end

    // sample store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_ir_present;
        end
        r_rd_bit <= r_mem[r_addr[AW-1:0]];
        r_rd_ok  <= (r_addr < POS_W'(r_cnt));
        r_rd_oob <= (r_addr >= POS_W'(STORE_BITS));
    end

    `NIRD_ASSERT_SAME(a_zero_fields, o_strobe && (o_frame_kind != KIND_FRAME), (o_address_word == 16'h0) && (o_command_byte == 8'h0) && (o_command_inverse == 8'h0))
    `NIRD_ASSERT_SAME(a_frame_complement, o_strobe && (o_frame_kind == KIND_FRAME), (o_command_byte ^ o_command_inverse) == 8'hff)
    `NIRD_ASSERT_NEXT(a_single_result, o_strobe, !o_strobe)
    `NIRD_ASSERT_SAME(a_idle_after_result, o_strobe, !busy)

endmodule
